[rtl/core/fswp_pkg.sv]
// Shared types, constants and elaboration-time angle tables for the wrapped-phase block.
`timescale 1ns / 1ps

package fswp_pkg;

    localparam int IN_W      = 8;
    localparam int OUT_W     = 15;
    localparam int STEPS     = 4;
    localparam int WIDE_FRAC = 60;

    // Four phase-shifted intensities of one fringe direction.
    typedef logic [STEPS-1:0][IN_W-1:0] steps_t;

    // One pixel: both fringe directions.
    typedef struct packed {
        steps_t x_step;
        steps_t y_step;
    } pixel_t;

    // Special-case flags carried down a lane beside the CORDIC vector.
    typedef struct packed {
        logic den_zero;
        logic num_zero;
        logic num_neg;
        logic neg;
    } flags_t;

    // Restoring division, used only while constants are worked out.
    function automatic longint unsigned div_u64(longint unsigned a, longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int k = 63; k >= 0; k--)
        begin
            r = {r[62:0], a[k]};
            if (r >= b)
            begin
                r    = r - b;
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(1/m) at WIDE_FRAC fraction bits, by the alternating series.
    function automatic longint unsigned atan_recip_wide(longint unsigned m);
        longint unsigned p;
        longint unsigned m2;
        longint unsigned sum;
        longint unsigned t;
        longint unsigned k;
        p   = div_u64(64'd1 << WIDE_FRAC, m);
        m2  = m * m;
        sum = 64'd0;
        k   = 64'd0;
        while (p != 64'd0)
        begin
            t = div_u64(p, 2 * k + 1);
            if (k[0] == 1'b0)
                sum = sum + t;
            else
                sum = sum - t;
            p = div_u64(p, m2);
            k = k + 1;
        end
        return sum;
    endfunction

    function automatic longint unsigned pi_quarter_wide();
        return 4 * atan_recip_wide(64'd5) - atan_recip_wide(64'd239);
    endfunction

    // Round a wide angle to nearest at the given fraction width.
    function automatic longint unsigned round_phase(longint unsigned wide, int frac);
        longint unsigned half;
        half = 64'd1 << (WIDE_FRAC - frac - 1);
        return (wide + half) >> (WIDE_FRAC - frac);
    endfunction

    // Rotation angle of CORDIC stage idx, atan(2^-idx).
    function automatic longint unsigned stage_angle(int idx, int frac);
        longint unsigned wide;
        if (idx == 0)
            wide = pi_quarter_wide();
        else
            wide = atan_recip_wide(64'd1 << idx);
        return round_phase(wide, frac);
    endfunction

    function automatic longint unsigned half_pi(int frac);
        return round_phase(2 * pi_quarter_wide(), frac);
    endfunction

endpackage

[rtl/core/fswp_cordic_stage.sv]
// One registered vectoring CORDIC micro-rotation.
`timescale 1ns / 1ps

module fswp_cordic_stage #(
    parameter int          IDX   = 0,
    parameter int          DW    = 27,
    parameter int          ZW    = 16,
    parameter int unsigned ANGLE = 0
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [DW-1:0]   x_in,
    input  logic signed [DW-1:0]   y_in,
    input  logic signed [ZW-1:0]   z_in,
    input  fswp_pkg::flags_t       flags_in,
    output logic signed [DW-1:0]   x_reg,
    output logic signed [DW-1:0]   y_reg,
    output logic signed [ZW-1:0]   z_reg,
    output fswp_pkg::flags_t       flags_reg
);

    logic signed [DW-1:0] x_sh;
    logic signed [DW-1:0] y_sh;
    logic signed [ZW-1:0] angle_c;
    logic signed [DW-1:0] x_next;
    logic signed [DW-1:0] y_next;
    logic signed [ZW-1:0] z_next;

    assign angle_c = ZW'(ANGLE);
    assign x_sh    = x_in >>> IDX;
    assign y_sh    = y_in >>> IDX;

    // Rotate towards the x axis: the sign of y picks the direction.
    always_comb
    begin
        if (!y_in[DW-1])
        begin
            x_next = x_in + y_sh;
            y_next = y_in - x_sh;
            z_next = z_in + angle_c;
        end
        else
        begin
            x_next = x_in - y_sh;
            y_next = y_in + x_sh;
            z_next = z_in - angle_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            flags_reg <= flags_in;
        end
    end

endmodule

[rtl/core/fswp_lane.sv]
// One fringe-direction lane: difference stage followed by a pipelined CORDIC.
`timescale 1ns / 1ps

module fswp_lane #(
    parameter int FRAC   = 13,
    parameter int STAGES = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  fswp_pkg::steps_t         steps,
    output logic signed [FRAC+2:0]   z_out,
    output fswp_pkg::flags_t         flags_out
);

    localparam int DW = STAGES + fswp_pkg::IN_W + 3;
    localparam int ZW = FRAC + 3;

    logic signed [fswp_pkg::IN_W:0]   num;
    logic signed [fswp_pkg::IN_W:0]   den;
    logic        [fswp_pkg::IN_W-1:0] num_abs;
    logic        [fswp_pkg::IN_W-1:0] den_abs;
    fswp_pkg::flags_t                 flags_next;

    logic signed [DW-1:0] x0_reg;
    logic signed [DW-1:0] y0_reg;
    fswp_pkg::flags_t     flags0_reg;

    logic signed [DW-1:0] x_reg     [STAGES];
    logic signed [DW-1:0] y_reg     [STAGES];
    logic signed [ZW-1:0] z_reg     [STAGES];
    fswp_pkg::flags_t     flags_reg [STAGES];

    // numerator I3 - I1, denominator I0 - I2
    assign num = $signed({1'b0, steps[3]}) - $signed({1'b0, steps[1]});
    assign den = $signed({1'b0, steps[0]}) - $signed({1'b0, steps[2]});

    assign num_abs = num[fswp_pkg::IN_W] ? fswp_pkg::IN_W'(-num) : num[fswp_pkg::IN_W-1:0];
    assign den_abs = den[fswp_pkg::IN_W] ? fswp_pkg::IN_W'(-den) : den[fswp_pkg::IN_W-1:0];

    always_comb
    begin
        flags_next.den_zero = (den == '0);
        flags_next.num_zero = (num == '0);
        flags_next.num_neg  = num[fswp_pkg::IN_W];
        flags_next.neg      = num[fswp_pkg::IN_W] ^ den[fswp_pkg::IN_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg     <= DW'({den_abs, {STAGES{1'b0}}});
            y0_reg     <= DW'({num_abs, {STAGES{1'b0}}});
            flags0_reg <= flags_next;
        end
    end

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        logic signed [DW-1:0] x_in;
        logic signed [DW-1:0] y_in;
        logic signed [ZW-1:0] z_in;
        fswp_pkg::flags_t     flags_in;

        if (k == 0)
        begin : g_head
            // the angle starts from zero
            assign x_in     = x0_reg;
            assign y_in     = y0_reg;
            assign z_in     = '0;
            assign flags_in = flags0_reg;
        end
        else
        begin : g_tail
            assign x_in     = x_reg[k-1];
            assign y_in     = y_reg[k-1];
            assign z_in     = z_reg[k-1];
            assign flags_in = flags_reg[k-1];
        end

        fswp_cordic_stage #(
            .IDX   (k),
            .DW    (DW),
            .ZW    (ZW),
            .ANGLE (32'(fswp_pkg::stage_angle(k, FRAC)))
        ) u_stage (
            .clk       (clk),
            .en        (en),
            .x_in      (x_in),
            .y_in      (y_in),
            .z_in      (z_in),
            .flags_in  (flags_in),
            .x_reg     (x_reg[k]),
            .y_reg     (y_reg[k]),
            .z_reg     (z_reg[k]),
            .flags_reg (flags_reg[k])
        );
    end

    assign z_out     = z_reg[STAGES-1];
    assign flags_out = flags_reg[STAGES-1];

endmodule

[rtl/core/fswp_merge.sv]
// Output stage: applies the special cases, clamps and signs both lane angles.
`timescale 1ns / 1ps

module fswp_merge #(
    parameter int FRAC = 13
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [FRAC+2:0]              z_x,
    input  fswp_pkg::flags_t                    flags_x,
    input  logic signed [FRAC+2:0]              z_y,
    input  fswp_pkg::flags_t                    flags_y,
    output logic signed [fswp_pkg::OUT_W-1:0]   phase_x_reg,
    output logic signed [fswp_pkg::OUT_W-1:0]   phase_y_reg
);

    localparam int ZW = FRAC + 3;
    localparam int EW = (ZW > fswp_pkg::OUT_W) ? ZW : fswp_pkg::OUT_W;
    localparam logic signed [ZW-1:0] HP = ZW'(fswp_pkg::half_pi(FRAC));

    logic signed [fswp_pkg::OUT_W-1:0] phase_x_next;
    logic signed [fswp_pkg::OUT_W-1:0] phase_y_next;

    function automatic logic signed [fswp_pkg::OUT_W-1:0] finish(
        logic signed [ZW-1:0] z,
        fswp_pkg::flags_t     f
    );
        logic signed [ZW-1:0] clamped;
        logic signed [ZW-1:0] res;
        logic signed [EW-1:0] ext;
        if (z[ZW-1])
            clamped = '0;
        else if (z > HP)
            clamped = HP;
        else
            clamped = z;
        if (f.den_zero)
        begin
            if (f.num_zero)
                res = '0;
            else if (f.num_neg)
                res = -HP;
            else
                res = HP;
        end
        else if (f.num_zero)
            res = '0;
        else if (f.neg)
            res = -clamped;
        else
            res = clamped;
        ext = EW'(res);
        return ext[fswp_pkg::OUT_W-1:0];
    endfunction

    assign phase_x_next = finish(z_x, flags_x);
    assign phase_y_next = finish(z_y, flags_y);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phase_x_reg <= phase_x_next;
            phase_y_reg <= phase_y_next;
        end
    end

endmodule

[rtl/core/four_step_wrapped_phase.sv]
// Top level of the four-step phase-shift wrapped-phase block.
`timescale 1ns / 1ps

// Takes one pixel per item: four phase-shifted 8-bit intensities for each of two fringe
// directions, and returns one item with both wrapped phases atan((I3-I1)/(I0-I2)) in
// [-pi/2, pi/2], radians scaled by 2^PHASE_FRAC_BITS in 15-bit two's complement. The two
// directions run in two identical lanes, each a difference stage followed by a fully
// pipelined vectoring CORDIC of ARCTAN_STAGES registered micro-rotations; a final stage
// merges the lanes, handles equal I0/I2 (result +pi/2, -pi/2 or 0 by the sign of I3-I1)
// and equal I1/I3 (result 0), clamps and signs the angle. Throughput is one item per
// clock while the output is not stalled; an item passes the difference register, the
// ARCTAN_STAGES CORDIC registers and the merge register. The whole pipeline advances only
// while the output register can move on; a one-item skid register on the input keeps
// in_stall a plain register output, so an item offered when the output stalls is still taken.
module four_step_wrapped_phase #(
    parameter int PHASE_FRAC_BITS = 13,
    parameter int ARCTAN_STAGES   = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [fswp_pkg::IN_W-1:0]           x_step_0,
    input  logic [fswp_pkg::IN_W-1:0]           x_step_1,
    input  logic [fswp_pkg::IN_W-1:0]           x_step_2,
    input  logic [fswp_pkg::IN_W-1:0]           x_step_3,
    input  logic [fswp_pkg::IN_W-1:0]           y_step_0,
    input  logic [fswp_pkg::IN_W-1:0]           y_step_1,
    input  logic [fswp_pkg::IN_W-1:0]           y_step_2,
    input  logic [fswp_pkg::IN_W-1:0]           y_step_3,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [fswp_pkg::OUT_W-1:0]   phase_x,
    output logic signed [fswp_pkg::OUT_W-1:0]   phase_y
);

    // prep stage + CORDIC stages + merge stage
    localparam int DEPTH = ARCTAN_STAGES + 2;
    localparam int ZW    = PHASE_FRAC_BITS + 3;
    localparam logic signed [fswp_pkg::OUT_W-1:0] HP_OUT =
        fswp_pkg::OUT_W'(fswp_pkg::half_pi(PHASE_FRAC_BITS));

    fswp_pkg::pixel_t in_pixel;
    fswp_pkg::pixel_t skid_reg;
    fswp_pkg::pixel_t feed_pixel;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    logic             in_accept;
    logic             feed_valid;
    logic             en;
    logic [DEPTH-1:0] vld_reg;

    logic signed [ZW-1:0] z_x;
    logic signed [ZW-1:0] z_y;
    fswp_pkg::flags_t     flags_x;
    fswp_pkg::flags_t     flags_y;

    assign in_pixel.x_step = {x_step_3, x_step_2, x_step_1, x_step_0};
    assign in_pixel.y_step = {y_step_3, y_step_2, y_step_1, y_step_0};

    // Advance every stage together unless the result in the output register is held.
    assign en        = !(out_valid && out_stall);
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;

    // Drain the skid first; it only ever fills while the pipeline is held.
    assign feed_pixel = skid_valid_reg ? skid_reg : in_pixel;
    assign feed_valid = skid_valid_reg || in_accept;

    always_comb
    begin
        skid_valid_next = skid_valid_reg;
        if (en)
            skid_valid_next = 1'b0;
        else if (in_accept)
            skid_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
            vld_reg        <= '0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
            if (en)
                vld_reg <= {vld_reg[DEPTH-2:0], feed_valid};
        end
    end

    // Hold the item that arrived while the pipeline was stalled.
    always_ff @(posedge clk)
    begin
        if (!en && in_accept)
            skid_reg <= in_pixel;
    end

    fswp_lane #(
        .FRAC   (PHASE_FRAC_BITS),
        .STAGES (ARCTAN_STAGES)
    ) u_lane_x (
        .clk       (clk),
        .en        (en),
        .steps     (feed_pixel.x_step),
        .z_out     (z_x),
        .flags_out (flags_x)
    );

    fswp_lane #(
        .FRAC   (PHASE_FRAC_BITS),
        .STAGES (ARCTAN_STAGES)
    ) u_lane_y (
        .clk       (clk),
        .en        (en),
        .steps     (feed_pixel.y_step),
        .z_out     (z_y),
        .flags_out (flags_y)
    );

    fswp_merge #(
        .FRAC (PHASE_FRAC_BITS)
    ) u_merge (
        .clk         (clk),
        .en          (en),
        .z_x         (z_x),
        .flags_x     (flags_x),
        .z_y         (z_y),
        .flags_y     (flags_y),
        .phase_x_reg (phase_x),
        .phase_y_reg (phase_y)
    );

    assign out_valid = vld_reg[DEPTH-1];

    // An item taken while the pipeline is held must land in the skid.
    a_skid_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !en) |=> skid_valid_reg)
        else $error("item accepted during a hold was not captured");

    // A held pipeline keeps every valid bit in place.
    a_hold_valids: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline valids moved while held");

    // Offered phases never exceed a quarter turn when the format fits the port.
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((PHASE_FRAC_BITS > 13) ||
                       ((phase_x <= HP_OUT) && (phase_x >= -HP_OUT) &&
                        (phase_y <= HP_OUT) && (phase_y >= -HP_OUT))))
        else $error("phase outside the wrapped range");

endmodule
